FILE: design/slr_pkg.sv
// ============================================================================
// slr_pkg - shared definitions for the shuffled Lehmer draw generator
// Constants of the generator, field widths and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
package slr_pkg;

  // Field widths of one request and one result.
  localparam int BOUND_W  = 32;
  localparam int SAMPLE_W = 31;
  localparam int SEED_W   = 31;

  // Park-Miller minimal standard generator.
  localparam int MULT_W = 15;
  localparam logic [MULT_W-1:0]   LEH_MULT   = 15'd16807;
  localparam logic [SAMPLE_W-1:0] LEH_MOD    = 31'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_CAP = 31'd2147483389;

  // Default number of entries in the shuffle table.
  localparam int TABLE_DEPTH_DEF = 32;

  // Warm-up steps run on top of one step per table entry when reseeding.
  localparam int WARMUP_EXTRA = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the request fields
    logic seed_load;  // load the cleaned seed into the generator
    logic step_mul;   // generator state times the multiplier
    logic step_fold;  // fold the product back modulo 2^31-1
    logic fill_we;    // write the folded value into the table
    logic fill_last;  // last fill step: this value becomes the last output
    logic idx_mul;    // reciprocal multiply for the table index
    logic tbl_read;   // read the table at the derived index
    logic swap;       // take the sample, store the fresh value in its place
    logic scale_mul;  // interval width times capped sample
    logic scale_est;  // quotient estimate
    logic scale_rem;  // remainder of the estimate
    logic scale_fix;  // final quotient and remainder flag
    logic out_load;   // load the output register
  } slr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_zero;  // table has never been filled
  } slr_sts_t;

endpackage

FILE: design/slr_req_if.sv
// ============================================================================
// slr_req_if - request channel of the shuffled Lehmer draw generator
// Valid/ready channel carrying the interval bounds and the reseed request.
// ============================================================================
interface slr_req_if
  import slr_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [BOUND_W-1:0]  lower_bound;
  logic signed [BOUND_W-1:0]  upper_bound;
  logic                       restart;
  logic        [SEED_W-1:0]   seed_value;

  modport source (
    output valid, lower_bound, upper_bound, restart, seed_value,
    input  ready
  );

  modport sink (
    input  valid, lower_bound, upper_bound, restart, seed_value,
    output ready
  );
endinterface

FILE: design/slr_rsp_if.sv
// ============================================================================
// slr_rsp_if - result channel of the shuffled Lehmer draw generator
// Valid/ready channel carrying the raw sample and the scaled value.
// ============================================================================
interface slr_rsp_if
  import slr_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic        [SAMPLE_W-1:0] raw_sample;
  logic signed [BOUND_W-1:0]  scaled_value;

  modport source (
    output valid, raw_sample, scaled_value,
    input  ready
  );

  modport sink (
    input  valid, raw_sample, scaled_value,
    output ready
  );
endinterface

FILE: design/slr_ram.sv
// ============================================================================
// slr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module slr_ram
  import slr_pkg::*;
#(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/slr_ctrl.sv
// ============================================================================
// slr_ctrl - sequencer of the shuffled Lehmer draw generator
// Steps through reseeding, table fill, the draw and the scaling, and owns
// the output register's valid flag.
// ============================================================================
module slr_ctrl
  import slr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_restart,
  input  logic                           out_ready,
  input  slr_sts_t                       sts,
  output logic                           in_ready,
  output logic                           out_valid,
  output slr_cmd_t                       cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEED  = 4'd1;
  localparam logic [3:0] S_FMUL  = 4'd2;
  localparam logic [3:0] S_FFOLD = 4'd3;
  localparam logic [3:0] S_DIDX  = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DSWAP = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SEST  = 4'd8;
  localparam logic [3:0] S_SREM  = 4'd9;
  localparam logic [3:0] S_SFIX  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign fill_addr = cnt_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_restart || sts.last_zero) ? S_SEED : S_DIDX;
        end
      end
      S_SEED: begin
        cmd.seed_load = 1'b1;
        cnt_nxt       = CW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
        state_nxt     = S_FMUL;
      end
      S_FMUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_FFOLD;
      end
      S_FFOLD: begin
        cmd.step_fold = 1'b1;
        cmd.fill_we   = (cnt_r < CW'(TABLE_DEPTH));
        if (cnt_r == '0) begin
          cmd.fill_last = 1'b1;
          state_nxt     = S_DIDX;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FMUL;
        end
      end
      S_DIDX: begin
        cmd.idx_mul  = 1'b1;
        cmd.step_mul = 1'b1;
        state_nxt    = S_DRD;
      end
      S_DRD: begin
        cmd.step_fold = 1'b1;
        cmd.tbl_read  = 1'b1;
        state_nxt     = S_DSWAP;
      end
      S_DSWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.scale_mul = 1'b1;
        state_nxt     = S_SEST;
      end
      S_SEST: begin
        cmd.scale_est = 1'b1;
        state_nxt     = S_SREM;
      end
      S_SREM: begin
        cmd.scale_rem = 1'b1;
        state_nxt     = S_SFIX;
      end
      S_SFIX: begin
        cmd.scale_fix = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/slr_dpath.sv
// ============================================================================
// slr_dpath - datapath of the shuffled Lehmer draw generator
// Generator state, shuffle table, table index and the interval scaling.
// ============================================================================
module slr_dpath
  import slr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slr_cmd_t                       cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
  input  logic signed [BOUND_W-1:0]      in_lower,
  input  logic signed [BOUND_W-1:0]      in_upper,
  input  logic [SEED_W-1:0]              in_seed,
  output slr_sts_t                       sts,
  output logic [SAMPLE_W-1:0]            out_sample,
  output logic signed [BOUND_W-1:0]      out_scaled
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = AW + 1;

  // Table index = last / BUCKET, done as a multiply by a rounded-up
  // reciprocal. With the shift of the sample width plus the bucket width the
  // quotient is exact for every 31-bit operand.
  localparam logic [63:0] BUCKET     = 64'd1 + (64'd2147483646 / TABLE_DEPTH);
  localparam int          BUCKET_W   = $clog2(BUCKET);
  localparam int          IDX_SH     = SAMPLE_W + BUCKET_W;
  localparam int          RECIP_W    = SAMPLE_W + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << IDX_SH) + BUCKET - 64'd1) / BUCKET;
  localparam logic [RECIP_W-1:0] IDX_RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam int PROD_W  = SAMPLE_W + MULT_W;  // generator product
  localparam int SPROD_W = BOUND_W + SAMPLE_W; // scaling product

  // Generator and shuffle state.
  logic [SAMPLE_W-1:0] lehmer_r;
  logic [SAMPLE_W-1:0] last_r;
  logic [PROD_W-1:0]   mul_r;
  logic [SAMPLE_W:0]   fold_sum;
  logic [SAMPLE_W-1:0] fold_val;
  logic [SAMPLE_W-1:0] seed_clean;

  // Request.
  logic signed [BOUND_W-1:0] lo_r;
  logic [BOUND_W:0]          diff_r;
  logic [SEED_W-1:0]         seed_r;

  // Index and table.
  logic [63:0]          idx_prod_r;
  logic [QW-1:0]        idx_q;
  logic [AW-1:0]        idx_sat;
  logic [AW-1:0]        idx_r;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  sample_r;

  // Scaling.
  logic [BOUND_W-1:0]   mag_r;
  logic                 neg_r;
  logic [BOUND_W:0]     diff_neg;
  logic [SAMPLE_W-1:0]  capped;
  logic [SPROD_W-1:0]   sprod_r;
  logic [SPROD_W-1:0]   est_sum;
  logic [BOUND_W-1:0]   q0_r;
  logic [BOUND_W+1:0]   rem_full;
  logic [BOUND_W:0]     rem_r;
  logic                 rem_ge;
  logic [BOUND_W:0]     rem_fin;
  logic [BOUND_W-1:0]   quo_r;
  logic                 nz_r;
  logic [BOUND_W+1:0]   lo_ext;
  logic [BOUND_W+1:0]   quo_up;
  logic [BOUND_W+1:0]   res_full;

  logic [SAMPLE_W-1:0]       out_sample_r;
  logic signed [BOUND_W-1:0] out_scaled_r;

  // Mersenne fold: hi part plus lo part, then one conditional subtract.
  assign fold_sum = {1'b0, mul_r[SAMPLE_W-1:0]}
                  + {{(SAMPLE_W + 1 - MULT_W){1'b0}}, mul_r[PROD_W-1:SAMPLE_W]};
  assign fold_val = (fold_sum >= {1'b0, LEH_MOD})
                  ? SAMPLE_W'(fold_sum - {1'b0, LEH_MOD})
                  : fold_sum[SAMPLE_W-1:0];

  // A seed of zero or equal to the modulus would lock the generator.
  assign seed_clean = (seed_r == '0 || seed_r == LEH_MOD) ? SAMPLE_W'(1) : seed_r;

  assign idx_q   = idx_prod_r[IDX_SH +: QW];
  assign idx_sat = (idx_q > QW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : idx_q[AW-1:0];

  assign ram_we    = cmd.fill_we || cmd.swap;
  assign ram_waddr = cmd.swap ? idx_r : fill_addr;
  assign ram_wdata = cmd.swap ? lehmer_r : fold_val;

  slr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.tbl_read),
    .raddr (idx_sat),
    .rdata (ram_rdata)
  );

  assign diff_neg = -diff_r;
  assign capped   = (sample_r > SAMPLE_CAP) ? SAMPLE_CAP : sample_r;

  // Estimate (N + N/2^31) / 2^31 lies at most one below N / (2^31-1).
  assign est_sum  = sprod_r + (sprod_r >> SAMPLE_W);
  // Remainder N - q0*(2^31-1) is below twice the modulus, so 34 bits suffice.
  assign rem_full = sprod_r[BOUND_W+1:0] - {q0_r[2:0], {SAMPLE_W{1'b0}}}
                  + {2'b00, q0_r};
  assign rem_ge   = (rem_r >= {2'b00, LEH_MOD});
  assign rem_fin  = rem_ge ? (rem_r - {2'b00, LEH_MOD}) : rem_r;

  // A negative width needs the quotient rounded toward minus infinity.
  assign lo_ext   = {{2{lo_r[BOUND_W-1]}}, lo_r};
  assign quo_up   = {2'b00, quo_r} + {{(BOUND_W + 1){1'b0}}, nz_r};
  assign res_full = neg_r ? (lo_ext - quo_up) : (lo_ext + {2'b00, quo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lehmer_r <= '0;
      last_r   <= '0;
    end else begin
      if (cmd.seed_load) begin
        lehmer_r <= seed_clean;
      end else if (cmd.step_fold) begin
        lehmer_r <= fold_val;
      end
      if (cmd.fill_last) begin
        last_r <= fold_val;
      end else if (cmd.swap) begin
        last_r <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lo_r   <= in_lower;
      diff_r <= {in_upper[BOUND_W-1], in_upper} - {in_lower[BOUND_W-1], in_lower};
      seed_r <= in_seed;
    end
    if (cmd.step_mul) begin
      mul_r <= lehmer_r * LEH_MULT;
    end
    if (cmd.idx_mul) begin
      idx_prod_r <= last_r * IDX_RECIP;
    end
    if (cmd.tbl_read) begin
      idx_r <= idx_sat;
    end
    if (cmd.swap) begin
      sample_r <= ram_rdata;
      neg_r    <= diff_r[BOUND_W];
      mag_r    <= diff_r[BOUND_W] ? diff_neg[BOUND_W-1:0] : diff_r[BOUND_W-1:0];
    end
    if (cmd.scale_mul) begin
      sprod_r <= mag_r * capped;
    end
    if (cmd.scale_est) begin
      q0_r <= est_sum[SPROD_W-1:SAMPLE_W];
    end
    if (cmd.scale_rem) begin
      rem_r <= rem_full[BOUND_W:0];
    end
    if (cmd.scale_fix) begin
      quo_r <= q0_r + {{(BOUND_W - 1){1'b0}}, rem_ge};
      nz_r  <= (rem_fin != '0);
    end
    if (cmd.out_load) begin
      out_sample_r <= sample_r;
      out_scaled_r <= res_full[BOUND_W-1:0];
    end
  end

  assign sts.last_zero = (last_r == '0);
  assign out_sample    = out_sample_r;
  assign out_scaled    = out_scaled_r;

endmodule

FILE: design/shuffled_lehmer_uniform_rng.sv
// ============================================================================
// shuffled_lehmer_uniform_rng - shuffled Lehmer uniform draw generator
// Minimal standard Lehmer generator behind a Bays-Durham shuffle table,
// with each draw scaled into a requested signed Q16.16 interval.
// ============================================================================
// Each request transfer yields exactly one result transfer. An ordinary draw
// runs from the request transfer until the block is ready for the next one:
// the sequencer walks through the index multiply, the table read, the table
// swap and a four-step scaling divide before loading the output register,
// and waits there while the output register still holds an untaken result.
// A request with restart set, and the first request after reset, first
// reseed the generator and run TABLE_DEPTH + 8 generator steps, each a
// multiply followed by the modulo fold. The shuffle table sits in a single
// RAM with one write and one registered read port; it needs no clearing,
// since it is always filled before it is first read. The output register
// holds a finished result until it is taken, and a new request is taken
// while it waits.
module shuffled_lehmer_uniform_rng
  import slr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slr_req_if.sink    in_chan,
  slr_rsp_if.source  out_chan
);

  localparam int AW = $clog2(TABLE_DEPTH);

  slr_cmd_t      cmd;
  slr_sts_t      sts;
  logic [AW-1:0] fill_addr;

  // The controller owns the handshake and the order of the work; the
  // datapath only does what each command bit asks for in that cycle.
  slr_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_restart (in_chan.restart),
    .out_ready  (out_chan.ready),
    .sts        (sts),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .cmd        (cmd),
    .fill_addr  (fill_addr)
  );

  // The datapath captures the request on the transfer, keeps the generator
  // and the table, and presents the registered result.
  slr_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .fill_addr  (fill_addr),
    .in_lower   (in_chan.lower_bound),
    .in_upper   (in_chan.upper_bound),
    .in_seed    (in_chan.seed_value),
    .sts        (sts),
    .out_sample (out_chan.raw_sample),
    .out_scaled (out_chan.scaled_value)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for the shuffled Lehmer draw generator
// Sends draw requests with random bounds, restarts and seeds, tracks the
// generator and its shuffle table alongside the block, and checks every
// result transfer against the draw worked out here.
// ============================================================================
module testbench;
  import slr_pkg::*;

  // Geometry and arithmetic of the generator as the block is built here.
  localparam int     DEPTH       = TABLE_DEPTH_DEF;
  localparam longint MODULUS     = 64'd2147483647;
  localparam longint BUCKET_SIZE = 1 + (MODULUS - 1) / DEPTH;

  // A reseeding draw keeps the block busy longest, and the receiver may stall
  // on top of that, so QUIET_LIMIT quiet cycles in a row can only mean that
  // the block has hung.
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_DRAWS  = 310;
  localparam int TAIL_CYCLES  = 20;

  // One draw request, with an optional scaled value that is known at a glance
  // (equal bounds give back the bound itself, whatever the sample).
  typedef struct {
    logic signed [BOUND_W-1:0] lower;
    logic signed [BOUND_W-1:0] upper;
    logic                      restart;
    logic        [SEED_W-1:0]  seed;
    bit                        scaled_known;
    logic signed [BOUND_W-1:0] scaled_typed;
  } draw_req_t;

  typedef struct {
    logic        [SAMPLE_W-1:0] raw_sample;
    logic signed [BOUND_W-1:0]  scaled_value;
  } draw_result_t;

  logic clk;
  logic rst_n;

  slr_req_if req_chan ();
  slr_rsp_if rsp_chan ();

  shuffled_lehmer_uniform_rng dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  always #10 clk = ~clk;

  // Shadow copy of the generator: state, last output and shuffle table. A
  // last output of zero means the table has never been filled.
  longint gen_state;
  longint prev_sample;
  longint shuffle_copy [DEPTH];

  // Draws accepted by the block whose results have not yet been transferred.
  draw_result_t pending_draws [$];

  int send_idle_pct;
  int recv_stall_pct;
  int draw_errors;
  int results_seen;
  int quiet_cycles;
  draw_result_t want;

  // Directed draws. The first one reaches the block with restart low but an
  // empty table, which must force a reseed all the same.
  localparam int DIRECTED_COUNT = 19;
  draw_req_t directed_draws [DIRECTED_COUNT] = '{
    '{32'sh0000_0000, 32'sh0001_0000, 1'b0, 31'd12345,      1'b0, 32'sh0000_0000},
    // Equal bounds: the scaled value is the bound, at zero and both extremes.
    '{32'sh0000_0000, 32'sh0000_0000, 1'b0, 31'd0,          1'b1, 32'sh0000_0000},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 31'd0,          1'b1, 32'sh7FFF_FFFF},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 31'd0,          1'b1, 32'sh8000_0000},
    // Widest interval in both directions.
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    // Narrow intervals, where rounding toward minus infinity shows.
    '{32'sh0000_0000, 32'sh0000_0001, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    '{32'shFFFF_FFFF, 32'sh0000_0000, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    '{32'sh0001_0000, 32'sh0000_0000, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    '{32'shFFFB_0000, 32'shFFFF_0000, 1'b0, 31'd0,          1'b0, 32'sh0000_0000},
    // Restarts: a zero seed and a seed equal to the modulus both fall back
    // to one, so the first three of these must give the same sample.
    '{32'sh0000_0000, 32'sh0001_0000, 1'b1, 31'd0,          1'b0, 32'sh0000_0000},
    '{32'sh0000_0000, 32'sh0001_0000, 1'b1, 31'd1,          1'b0, 32'sh0000_0000},
    '{32'sh0000_0000, 32'sh0001_0000, 1'b1, 31'h7FFF_FFFF,  1'b0, 32'sh0000_0000},
    '{32'sh0000_0000, 32'sh0001_0000, 1'b1, 31'h7FFF_FFFE,  1'b0, 32'sh0000_0000},
    '{32'sh1234_5678, 32'sh1234_5678, 1'b1, 31'h2AAA_AAAA,  1'b1, 32'sh1234_5678},
    '{32'shC000_0000, 32'sh4000_0000, 1'b1, 31'h5555_5555,  1'b0, 32'sh0000_0000},
    // Seed is ignored while restart is low.
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 31'h7FFF_FFFF,  1'b0, 32'sh0000_0000},
    '{32'sh0001_0000, 32'sh0002_0000, 1'b0, 31'h1234_5678,  1'b0, 32'sh0000_0000},
    '{32'shFFFF_0000, 32'sh0001_0000, 1'b0, 31'd99,         1'b0, 32'sh0000_0000}
  };

  // One step of the minimal standard generator, done directly in 64 bits.
  function automatic longint lehmer_advance(input longint s);
    return (s * longint'(LEH_MULT)) % MODULUS;
  endfunction

  // Reseed: warm up for eight steps, then fill the table from the top index
  // down; the bottom entry becomes the last output.
  function automatic void refill_shuffle_table(input logic [SEED_W-1:0] seed);
    longint s;
    s = longint'(seed);
    if (s < 1 || s >= MODULUS) s = 1;
    for (int j = DEPTH + WARMUP_EXTRA - 1; j >= 0; j--) begin
      s = lehmer_advance(s);
      if (j < DEPTH) shuffle_copy[j] = s;
    end
    gen_state   = s;
    prev_sample = shuffle_copy[0];
  endfunction

  // Work out one draw and move the shadow generator on by it.
  function automatic draw_result_t predict_draw(input draw_req_t req);
    longint lo;
    longint hi;
    longint idx;
    longint sample;
    longint capped;
    longint prod;
    longint quot;
    longint sum;
    draw_result_t res;
    lo = longint'(req.lower);
    hi = longint'(req.upper);
    if (req.restart || prev_sample == 0) refill_shuffle_table(req.seed);
    gen_state = lehmer_advance(gen_state);
    idx = prev_sample / BUCKET_SIZE;
    if (idx > DEPTH - 1) idx = DEPTH - 1;
    sample = shuffle_copy[idx];
    shuffle_copy[idx] = gen_state;
    prev_sample = sample;
    capped = (sample > longint'(SAMPLE_CAP)) ? longint'(SAMPLE_CAP) : sample;
    // The span fits 33 bits and the capped sample 31, so the product fits.
    prod = (hi - lo) * capped;
    quot = prod / MODULUS;
    if (prod < 0 && quot * MODULUS != prod) quot = quot - 1;
    sum = lo + quot;
    res.raw_sample   = sample[SAMPLE_W-1:0];
    res.scaled_value = sum[BOUND_W-1:0];
    return res;
  endfunction

  // Random request. Half the bounds are fully random; the rest are equal,
  // narrow, reversed or nearly empty intervals. Restarts come now and then,
  // and some of them carry the seeds that fall back to one.
  function automatic draw_req_t random_draw();
    draw_req_t req;
    req.lower        = $urandom();
    req.scaled_known = 1'b0;
    req.scaled_typed = '0;
    case ($urandom_range(7))
      4: req.upper = req.lower;
      5: req.upper = req.lower + $urandom_range(32'h0003_FFFF);
      6: req.upper = req.lower - $urandom_range(32'h0003_FFFF);
      7: req.upper = req.lower + $urandom_range(3);
      default: req.upper = $urandom();
    endcase
    req.restart = ($urandom_range(31) == 0);
    case ($urandom_range(15))
      0: req.seed = '0;
      1: req.seed = '1;
      default: req.seed = SEED_W'($urandom());
    endcase
    return req;
  endfunction

  // Offer one request, idling beforehand at the current rate, and wait for
  // its transfer. The expected result is queued at the edge of the transfer.
  // Valid is left high on return, so a following request goes out at once.
  task automatic send_draw(input draw_req_t req);
    draw_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_chan.valid <= 1'b0;
      @(posedge clk);
    end
    req_chan.valid       <= 1'b1;
    req_chan.lower_bound <= req.lower;
    req_chan.upper_bound <= req.upper;
    req_chan.restart     <= req.restart;
    req_chan.seed_value  <= req.seed;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    res = predict_draw(req);
    if (req.scaled_known) res.scaled_value = req.scaled_typed;
    pending_draws.push_back(res);
  endtask

  // Hold the request channel quiet until every queued draw has come back.
  // The extra edge keeps the lowering of valid and any later raise apart.
  task automatic drain_draws();
    req_chan.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result side: check each transfer against the oldest queued draw, then
  // choose ready for the next cycle at the current stall rate.
  always @(posedge clk) begin
    if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
      results_seen = results_seen + 1;
      if (pending_draws.size() == 0) begin
        draw_errors = draw_errors + 1;
        if (draw_errors <= MAX_REPORTS)
          $display("result %0d: unexpected transfer, raw_sample %0d scaled_value %0d",
                   results_seen, rsp_chan.raw_sample, rsp_chan.scaled_value);
      end else begin
        want = pending_draws.pop_front();
        if (rsp_chan.raw_sample !== want.raw_sample ||
            rsp_chan.scaled_value !== want.scaled_value) begin
          draw_errors = draw_errors + 1;
          if (draw_errors <= MAX_REPORTS)
            $display("result %0d: raw_sample expected %0d got %0d, scaled_value expected %0d got %0d",
                     results_seen, want.raw_sample, rsp_chan.raw_sample,
                     want.scaled_value, rsp_chan.scaled_value);
        end
      end
    end
    rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any transfer on either channel shows the block is alive.
  always @(posedge clk) begin
    if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("shuffled_lehmer_uniform_rng test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    req_chan.valid       = 1'b0;
    req_chan.lower_bound = '0;
    req_chan.upper_bound = '0;
    req_chan.restart     = 1'b0;
    req_chan.seed_value  = '0;
    rsp_chan.ready       = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    draw_errors          = 0;
    results_seen         = 0;
    quiet_cycles         = 0;
    gen_state            = 0;
    prev_sample          = 0;
    foreach (shuffle_copy[i]) shuffle_copy[i] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed draws with both sides running flat out.
    foreach (directed_draws[i]) send_draw(directed_draws[i]);

    // Random phases: no idling, a sluggish sender, a sluggish receiver and a
    // light sprinkle on both. Before each phase the sender waits until every
    // outstanding result has been transferred.
    for (int phase = 0; phase < 4; phase++) begin
      drain_draws();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < PHASE_DRAWS; n++) send_draw(random_draw());
    end

    drain_draws();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (draw_errors == 0 && pending_draws.size() == 0) begin
      $display("shuffled_lehmer_uniform_rng test passed");
    end else begin
      $display("shuffled_lehmer_uniform_rng test failed");
    end
    $finish;
  end

endmodule
